/* rtl/mmc_crc7_serial_and_bus_lanes_top_macros.svh */
// ----------------------------------------------------------------------------
// MMC CRC-7 serial and bus lanes: assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MMC_CRC7_SERIAL_AND_BUS_LANES_TOP_MACROS_SVH
`define MMC_CRC7_SERIAL_AND_BUS_LANES_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define MMC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define MMC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MMC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define MMC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

/* rtl/mmc_crc7_pkg.sv */
// ----------------------------------------------------------------------------
// MMC CRC-7 package
// Constants, types and CRC-7 (x^7 + x^3 + 1) helper functions.
// ----------------------------------------------------------------------------
package mmc_crc7_pkg;

    localparam int CRC_W           = 7;
    localparam int BYTE_W          = 8;
    localparam int BUS_LANES       = 8;
    localparam int POS_W           = 3;
    localparam int OUT_COUNT_W     = 16;
    localparam int DEF_LANES       = 8;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int REG_IDX_W       = APB_ADDR_W - 2;

    localparam logic [CRC_W-1:0]     POLY_TAPS        = 7'h09;
    localparam logic [POS_W-1:0]     LAST_POS         = 3'd7;
    localparam logic [BYTE_W-1:0]    END_BYTE         = 8'hff;
    localparam logic [REG_IDX_W-1:0] REG_END_BIT_MODE = 1'b0;

    // Item kinds on the input channel.
    typedef enum logic {
        MODE_DATA   = 1'b0,
        MODE_FINISH = 1'b1
    } item_mode_t;

    // Control from the front end to the merge stage.
    typedef struct packed {
        logic load;
        logic end_bit;
    } merge_ctrl_t;

    // Status from the merge stage back to the front end.
    typedef struct packed {
        logic busy;
        logic run_done;
    } merge_stat_t;

    // One bit shifted into a CRC-7 register.
    function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] r,
                                                   input logic bit_in);
        logic             fb;
        logic [CRC_W-1:0] s;
        fb = bit_in ^ r[CRC_W-1];
        s  = {r[CRC_W-2:0], 1'b0};
        if (fb)
        begin
            s = s ^ POLY_TAPS;
        end
        return s;
    endfunction

    // A whole byte shifted in, MSB first.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] r,
                                                  input logic [BYTE_W-1:0] d);
        logic [CRC_W-1:0] s;
        s = r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            s = crc_shift(s, d[BYTE_W-1-i]);
        end
        return s;
    endfunction

    // Reported form of a CRC: plain, or with the end bit appended.
    function automatic logic [BYTE_W-1:0] report_crc(input logic [CRC_W-1:0] r,
                                                     input logic end_bit);
        return end_bit ? {r, 1'b1} : {1'b0, r};
    endfunction

endpackage

/* rtl/mmc_crc7_lane.sv */
// ----------------------------------------------------------------------------
// MMC CRC-7 bus lane
// CRC-7 register of one data line, fed one bit per data beat.
// ----------------------------------------------------------------------------
module mmc_crc7_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shift_en,
    input  logic                            clear,
    input  logic                            data_bit,
    output logic [mmc_crc7_pkg::CRC_W-1:0]  crc
);

    logic [mmc_crc7_pkg::CRC_W-1:0] crc_reg;
    logic [mmc_crc7_pkg::CRC_W-1:0] crc_next;

    // A finish clears the lane; a data beat shifts in one bit.
    always_comb
    begin
        crc_next = crc_reg;
        if (clear)
        begin
            crc_next = '0;
        end
        else if (shift_en)
        begin
            crc_next = mmc_crc7_pkg::crc_shift(crc_reg, data_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

/* rtl/mmc_crc7_merge.sv */
// ----------------------------------------------------------------------------
// MMC CRC-7 merge stage
// Snapshots the lane and serial CRCs on a finish and plays out the run of
// eight result beats, transposing the lane CRCs into bus bytes.
// ----------------------------------------------------------------------------
module mmc_crc7_merge (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  mmc_crc7_pkg::merge_ctrl_t                              ctrl,
    input  logic [mmc_crc7_pkg::BUS_LANES-1:0][mmc_crc7_pkg::CRC_W-1:0] lane_in,
    input  logic [mmc_crc7_pkg::CRC_W-1:0]                         serial_in,
    input  logic [mmc_crc7_pkg::OUT_COUNT_W-1:0]                   count_in,
    input  logic                                                   out_ready,
    output mmc_crc7_pkg::merge_stat_t                              stat,
    output logic                                                   out_valid,
    output logic [mmc_crc7_pkg::POS_W-1:0]                         lane_number,
    output logic [mmc_crc7_pkg::BYTE_W-1:0]                        lane_crc,
    output logic [mmc_crc7_pkg::BYTE_W-1:0]                        bus_byte,
    output logic                                                   bus_byte_valid,
    output logic [mmc_crc7_pkg::BYTE_W-1:0]                        serial_crc,
    output logic [mmc_crc7_pkg::OUT_COUNT_W-1:0]                   byte_count,
    output logic                                                   last
);

    logic [mmc_crc7_pkg::BUS_LANES-1:0][mmc_crc7_pkg::CRC_W-1:0] lane_snap_reg;
    logic [mmc_crc7_pkg::CRC_W-1:0]       serial_snap_reg;
    logic [mmc_crc7_pkg::OUT_COUNT_W-1:0] count_snap_reg;
    logic [mmc_crc7_pkg::POS_W-1:0]       pos_reg;
    logic [mmc_crc7_pkg::POS_W-1:0]       pos_next;
    logic                                 busy_reg;
    logic                                 busy_next;
    logic                                 beat_taken;
    logic                                 at_last;
    logic [mmc_crc7_pkg::POS_W-1:0]       bit_sel;
    logic [mmc_crc7_pkg::BYTE_W-1:0]      bus_bits;

    assign beat_taken = busy_reg && out_ready;
    assign at_last    = (pos_reg == mmc_crc7_pkg::LAST_POS);

    // Run sequencing: a load restarts at position zero.
    always_comb
    begin
        pos_next  = pos_reg;
        busy_next = busy_reg;
        priority if (ctrl.load)
        begin
            pos_next  = '0;
            busy_next = 1'b1;
        end
        else if (beat_taken)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else
        begin
            pos_next  = pos_reg;
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            busy_reg <= busy_next;
        end
    end

    // Snapshot of the finished CRCs.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            lane_snap_reg   <= lane_in;
            serial_snap_reg <= serial_in;
            count_snap_reg  <= count_in;
        end
    end

    // Bus byte k takes bit 6-k of every lane CRC.
    assign bit_sel = mmc_crc7_pkg::POS_W'(mmc_crc7_pkg::CRC_W - 1) - pos_reg;

    always_comb
    begin
        for (int i = 0; i < mmc_crc7_pkg::BUS_LANES; i++)
        begin
            bus_bits[i] = lane_snap_reg[i][bit_sel];
        end
    end

    // Result beat fields.
    assign out_valid      = busy_reg;
    assign lane_number    = mmc_crc7_pkg::LAST_POS - pos_reg;
    assign lane_crc       = mmc_crc7_pkg::report_crc(lane_snap_reg[pos_reg], ctrl.end_bit);
    assign bus_byte       = at_last ? (ctrl.end_bit ? mmc_crc7_pkg::END_BYTE : '0)
                                    : bus_bits;
    assign bus_byte_valid = !at_last || ctrl.end_bit;
    assign serial_crc     = mmc_crc7_pkg::report_crc(serial_snap_reg, ctrl.end_bit);
    assign byte_count     = count_snap_reg;
    assign last           = at_last;

    assign stat.busy     = busy_reg;
    assign stat.run_done = beat_taken && at_last;

endmodule

/* rtl/mmc_crc7_serial_and_bus_lanes_top.sv */
// ----------------------------------------------------------------------------
// MMC CRC-7 serial and bus lanes, top level
// Serial and per-line CRC-7 over a byte stream with eight-beat readout.
// ----------------------------------------------------------------------------
// Data beats (mode 0) are absorbed at one byte per clock: the serial CRC-7
// takes all eight bits MSB first, and each of the LANES line CRCs takes its
// own bit of the byte, all in the same cycle. A finish beat (mode 1) copies
// the CRCs and byte count into the merge stage, clears the live state and
// starts a run of eight result beats, one per clock while out_ready is high;
// data beats keep flowing during the run. A further finish beat is accepted
// once the merge stage is free or its last beat leaves in that same cycle.
// end_bit_mode sits at APB byte address 0 and must only change while idle.
// ----------------------------------------------------------------------------
`include "mmc_crc7_serial_and_bus_lanes_top_macros.svh"

module mmc_crc7_serial_and_bus_lanes_top #(
    parameter int LANES       = mmc_crc7_pkg::DEF_LANES,
    parameter int COUNT_WIDTH = mmc_crc7_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // APB configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mmc_crc7_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mmc_crc7_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mmc_crc7_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    // Input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   mode,
    input  logic [mmc_crc7_pkg::BYTE_W-1:0]        data_byte,
    // Output channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mmc_crc7_pkg::POS_W-1:0]         lane_number,
    output logic [mmc_crc7_pkg::BYTE_W-1:0]        lane_crc,
    output logic [mmc_crc7_pkg::BYTE_W-1:0]        bus_byte,
    output logic                                   bus_byte_valid,
    output logic [mmc_crc7_pkg::BYTE_W-1:0]        serial_crc,
    output logic [mmc_crc7_pkg::OUT_COUNT_W-1:0]   byte_count,
    output logic                                   last
);

    logic                                 end_bit_mode_reg;
    logic                                 cfg_write;
    logic                                 cfg_hit;
    logic                                 in_take;
    logic                                 data_take;
    logic                                 finish_take;
    logic [mmc_crc7_pkg::CRC_W-1:0]       serial_reg;
    logic [mmc_crc7_pkg::CRC_W-1:0]       serial_next;
    logic [COUNT_WIDTH-1:0]               count_reg;
    logic [COUNT_WIDTH-1:0]               count_next;
    logic [mmc_crc7_pkg::OUT_COUNT_W-1:0] count_clip;
    logic [mmc_crc7_pkg::BUS_LANES-1:0][mmc_crc7_pkg::CRC_W-1:0] lane_crc_vec;
    mmc_crc7_pkg::merge_ctrl_t            merge_ctrl;
    mmc_crc7_pkg::merge_stat_t            merge_stat;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[mmc_crc7_pkg::APB_ADDR_W-1:2] == mmc_crc7_pkg::REG_END_BIT_MODE);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? mmc_crc7_pkg::APB_DATA_W'(end_bit_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_bit_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            end_bit_mode_reg <= pwdata[0];
        end
    end

    // Input handshake: a finish needs a free merge stage, or one whose last beat is taken.
    assign in_ready    = (mode == mmc_crc7_pkg::MODE_DATA) || !merge_stat.busy
                         || merge_stat.run_done;
    assign in_take     = in_valid && in_ready;
    assign data_take   = in_take && (mode == mmc_crc7_pkg::MODE_DATA);
    assign finish_take = in_take && (mode == mmc_crc7_pkg::MODE_FINISH);

    // Serial CRC and saturating byte counter.
    always_comb
    begin
        serial_next = serial_reg;
        count_next  = count_reg;
        if (finish_take)
        begin
            serial_next = '0;
            count_next  = '0;
        end
        else if (data_take)
        begin
            serial_next = mmc_crc7_pkg::crc_byte(serial_reg, data_byte);
            if (!(&count_reg))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            serial_reg <= serial_next;
            count_reg  <= count_next;
        end
    end

    // Reported count saturates at the field width.
    generate
        if (COUNT_WIDTH > mmc_crc7_pkg::OUT_COUNT_W)
        begin : g_count_wide
            assign count_clip = (|count_reg[COUNT_WIDTH-1:mmc_crc7_pkg::OUT_COUNT_W])
                                ? '1 : count_reg[mmc_crc7_pkg::OUT_COUNT_W-1:0];
        end
        else
        begin : g_count_narrow
            assign count_clip = mmc_crc7_pkg::OUT_COUNT_W'(count_reg);
        end
    endgenerate

    // Line CRC lanes; lanes that are not kept read as zero.
    generate
        for (genvar g = 0; g < mmc_crc7_pkg::BUS_LANES; g++)
        begin : g_lane
            if (g < LANES)
            begin : g_kept
                mmc_crc7_lane u_lane (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (data_take),
                    .clear    (finish_take),
                    .data_bit (data_byte[mmc_crc7_pkg::BYTE_W-1-g]),
                    .crc      (lane_crc_vec[g])
                );
            end
            else
            begin : g_absent
                assign lane_crc_vec[g] = '0;
            end
        end
    endgenerate

    // Merge stage.
    assign merge_ctrl.load    = finish_take;
    assign merge_ctrl.end_bit = end_bit_mode_reg;

    mmc_crc7_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (merge_ctrl),
        .lane_in        (lane_crc_vec),
        .serial_in      (serial_reg),
        .count_in       (count_clip),
        .out_ready      (out_ready),
        .stat           (merge_stat),
        .out_valid      (out_valid),
        .lane_number    (lane_number),
        .lane_crc       (lane_crc),
        .bus_byte       (bus_byte),
        .bus_byte_valid (bus_byte_valid),
        .serial_crc     (serial_crc),
        .byte_count     (byte_count),
        .last           (last)
    );

    // Assertions.
    `MMC_ASSERT_NXT(a_finish_starts_run, clk, rst_n, finish_take, out_valid && (lane_number == mmc_crc7_pkg::LAST_POS))
    `MMC_ASSERT_NXT(a_finish_clears, clk, rst_n, finish_take, (serial_reg == '0) && (count_reg == '0))
    `MMC_ASSERT_NXT(a_run_continues, clk, rst_n, out_valid && out_ready && !last && !finish_take, out_valid)
    `MMC_ASSERT_IMP(a_last_bus_valid, clk, rst_n, out_valid && last, bus_byte_valid == end_bit_mode_reg)

endmodule

/* sim/mmc_crc7_readout_checker.sv */
// ----------------------------------------------------------------------------
// MMC CRC-7 readout checker
// Watches the configuration port and both beat channels of the CRC-7 block,
// keeps its own copy of the serial and per-line CRC state, and compares every
// result beat, field by field, with the oldest predicted readout beat.
// ----------------------------------------------------------------------------
module mmc_crc7_readout_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port, observed only
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mmc_crc7_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mmc_crc7_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                                   pready,
    // Input channel, observed only
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   mode,
    input  logic [mmc_crc7_pkg::BYTE_W-1:0]        data_byte,
    // Output channel, observed only
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [mmc_crc7_pkg::POS_W-1:0]         lane_number,
    input  logic [mmc_crc7_pkg::BYTE_W-1:0]        lane_crc,
    input  logic [mmc_crc7_pkg::BYTE_W-1:0]        bus_byte,
    input  logic                                   bus_byte_valid,
    input  logic [mmc_crc7_pkg::BYTE_W-1:0]        serial_crc,
    input  logic [mmc_crc7_pkg::OUT_COUNT_W-1:0]   byte_count,
    input  logic                                   last,
    // Status for the testbench top
    output int                                     fail_count,
    output int                                     pending,
    output int                                     beats_checked
);

    localparam logic [mmc_crc7_pkg::CRC_W-1:0] CRC7_TAPS   = 7'h09;
    localparam int                             MAX_PRINTED = 20;

    // One predicted result beat of a readout run.
    typedef struct packed {
        logic [mmc_crc7_pkg::POS_W-1:0]       lane_number;
        logic [mmc_crc7_pkg::BYTE_W-1:0]      lane_crc;
        logic [mmc_crc7_pkg::BYTE_W-1:0]      bus_byte;
        logic                                 bus_byte_valid;
        logic [mmc_crc7_pkg::BYTE_W-1:0]      serial_crc;
        logic [mmc_crc7_pkg::OUT_COUNT_W-1:0] byte_count;
        logic                                 last;
    } readout_beat_t;

    logic [mmc_crc7_pkg::CRC_W-1:0]       serial_acc;
    logic [mmc_crc7_pkg::CRC_W-1:0]       line_acc [mmc_crc7_pkg::BUS_LANES];
    logic [mmc_crc7_pkg::OUT_COUNT_W-1:0] bytes_acc;
    logic                                 end_bit_on;
    readout_beat_t                        readout_due [$];
    readout_beat_t                        want;

    // Advance a CRC-7 register by one input bit.
    function automatic logic [mmc_crc7_pkg::CRC_W-1:0] crc7_shift_in(
        input logic [mmc_crc7_pkg::CRC_W-1:0] acc,
        input logic b);
        logic [mmc_crc7_pkg::CRC_W-1:0] nxt;
        nxt = {acc[mmc_crc7_pkg::CRC_W-2:0], 1'b0};
        if (acc[mmc_crc7_pkg::CRC_W-1] ^ b)
        begin
            nxt = nxt ^ CRC7_TAPS;
        end
        return nxt;
    endfunction

    // CRC as it leaves the block: bare, or with the end bit below it.
    function automatic logic [mmc_crc7_pkg::BYTE_W-1:0] crc_as_sent(
        input logic [mmc_crc7_pkg::CRC_W-1:0] acc);
        if (end_bit_on)
        begin
            return {acc, 1'b1};
        end
        return {1'b0, acc};
    endfunction

    // A data beat feeds the serial CRC MSB first and one bit to each line.
    task automatic absorb_byte(input logic [mmc_crc7_pkg::BYTE_W-1:0] d);
        for (int b = mmc_crc7_pkg::BYTE_W - 1; b >= 0; b--)
        begin
            serial_acc = crc7_shift_in(serial_acc, d[b]);
        end
        for (int i = 0; i < mmc_crc7_pkg::BUS_LANES; i++)
        begin
            line_acc[i] = crc7_shift_in(line_acc[i], d[mmc_crc7_pkg::BYTE_W-1-i]);
        end
        if (bytes_acc != {mmc_crc7_pkg::OUT_COUNT_W{1'b1}})
        begin
            bytes_acc = bytes_acc + 1'b1;
        end
    endtask

    // A finish beat predicts eight result beats and clears the CRC state.
    task automatic queue_readout();
        readout_beat_t rb;
        for (int k = 0; k < 8; k++)
        begin
            rb.lane_number    = mmc_crc7_pkg::LAST_POS - mmc_crc7_pkg::POS_W'(k);
            rb.lane_crc       = crc_as_sent(line_acc[k]);
            rb.bus_byte       = '0;
            rb.bus_byte_valid = 1'b1;
            if (k < 7)
            begin
                for (int i = 0; i < mmc_crc7_pkg::BUS_LANES; i++)
                begin
                    rb.bus_byte[i] = line_acc[i][6-k];
                end
            end
            else if (end_bit_on)
            begin
                rb.bus_byte = 8'hff;
            end
            else
            begin
                rb.bus_byte_valid = 1'b0;
            end
            rb.serial_crc = crc_as_sent(serial_acc);
            rb.byte_count = bytes_acc;
            rb.last       = (k == 7);
            readout_due.push_back(rb);
        end
        serial_acc = '0;
        bytes_acc  = '0;
        for (int i = 0; i < mmc_crc7_pkg::BUS_LANES; i++)
        begin
            line_acc[i] = '0;
        end
    endtask

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (fail_count < MAX_PRINTED)
        begin
            $display("%0t: result mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, exp_val);
        end
        fail_count++;
    endtask

    // Track configuration, predict on accepted input beats, check output beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_acc    = '0;
            bytes_acc     = '0;
            end_bit_on    = 1'b0;
            fail_count    = 0;
            beats_checked = 0;
            for (int i = 0; i < mmc_crc7_pkg::BUS_LANES; i++)
            begin
                line_acc[i] = '0;
            end
            readout_due.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (readout_due.size() == 0)
                begin
                    report_mismatch("unexpected beat, lane_number", 32'(lane_number), 0);
                end
                else
                begin
                    want = readout_due.pop_front();
                    if (lane_number !== want.lane_number)
                        report_mismatch("lane_number", 32'(lane_number),
                                        32'(want.lane_number));
                    if (lane_crc !== want.lane_crc)
                        report_mismatch("lane_crc", 32'(lane_crc), 32'(want.lane_crc));
                    if (bus_byte !== want.bus_byte)
                        report_mismatch("bus_byte", 32'(bus_byte), 32'(want.bus_byte));
                    if (bus_byte_valid !== want.bus_byte_valid)
                        report_mismatch("bus_byte_valid", 32'(bus_byte_valid),
                                        32'(want.bus_byte_valid));
                    if (serial_crc !== want.serial_crc)
                        report_mismatch("serial_crc", 32'(serial_crc),
                                        32'(want.serial_crc));
                    if (byte_count !== want.byte_count)
                        report_mismatch("byte_count", 32'(byte_count),
                                        32'(want.byte_count));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                    beats_checked++;
                end
            end

            if (in_valid && in_ready)
            begin
                if (mode == mmc_crc7_pkg::MODE_FINISH)
                begin
                    queue_readout();
                end
                else
                begin
                    absorb_byte(data_byte);
                end
            end

            if (psel && penable && pwrite && pready &&
                paddr[mmc_crc7_pkg::APB_ADDR_W-1:2] == mmc_crc7_pkg::REG_END_BIT_MODE)
            begin
                end_bit_on = pwdata[0];
            end

            pending <= readout_due.size();
        end
    end

endmodule

/* sim/tb_mmc_crc7_serial_and_bus_lanes_top.sv */
// ----------------------------------------------------------------------------
// MMC CRC-7 serial and bus lanes testbench
// Drives data and finish beats into the CRC-7 block under both end-bit
// settings and several idling patterns, holds the output off long enough to
// back up the input, and reports the verdict from the readout checker's
// failure and pending counts.
// ----------------------------------------------------------------------------
module tb_mmc_crc7_serial_and_bus_lanes_top;

    localparam int HOLD_CYCLES      = 150;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int ITEMS_PER_PHASE  = 52;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [mmc_crc7_pkg::APB_ADDR_W-1:0]  paddr;
    logic [mmc_crc7_pkg::APB_DATA_W-1:0]  pwdata;
    logic [mmc_crc7_pkg::APB_DATA_W-1:0]  prdata;
    logic                                 pready;
    logic                                 in_valid;
    logic                                 in_ready;
    mmc_crc7_pkg::item_mode_t             mode;
    logic [mmc_crc7_pkg::BYTE_W-1:0]      data_byte;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [mmc_crc7_pkg::POS_W-1:0]       lane_number;
    logic [mmc_crc7_pkg::BYTE_W-1:0]      lane_crc;
    logic [mmc_crc7_pkg::BYTE_W-1:0]      bus_byte;
    logic                                 bus_byte_valid;
    logic [mmc_crc7_pkg::BYTE_W-1:0]      serial_crc;
    logic [mmc_crc7_pkg::OUT_COUNT_W-1:0] byte_count;
    logic                                 last;

    logic                    hold_req;
    int                      idle_pct;
    int                      stall_pct;
    int                      beats_sent;
    int                      finishes_sent;
    int                      ck_fails;
    int                      ck_pending;
    int                      ck_beats;
    int                      quiet_cycles;

    int idle_tab  [4] = '{0, 63, 0, 35};
    int stall_tab [4] = '{0, 0, 63, 35};

    always #2 clk = ~clk;

    mmc_crc7_serial_and_bus_lanes_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lane_number    (lane_number),
        .lane_crc       (lane_crc),
        .bus_byte       (bus_byte),
        .bus_byte_valid (bus_byte_valid),
        .serial_crc     (serial_crc),
        .byte_count     (byte_count),
        .last           (last)
    );

    mmc_crc7_readout_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lane_number    (lane_number),
        .lane_crc       (lane_crc),
        .bus_byte       (bus_byte),
        .bus_byte_valid (bus_byte_valid),
        .serial_crc     (serial_crc),
        .byte_count     (byte_count),
        .last           (last),
        .fail_count     (ck_fails),
        .pending        (ck_pending),
        .beats_checked  (ck_beats)
    );

    // Offer one input beat after random idle cycles and wait for its acceptance.
    task automatic send_item(input mmc_crc7_pkg::item_mode_t m,
                             input logic [mmc_crc7_pkg::BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
        if (m == mmc_crc7_pkg::MODE_FINISH)
        begin
            finishes_sent++;
        end
    endtask

    // A run of random data bytes closed by a finish; some runs are empty or long.
    task automatic send_run();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            n = 0;
        else if (pick < 85)
            n = $urandom_range(1, 8);
        else
            n = $urandom_range(9, 24);
        repeat (n)
        begin
            send_item(mmc_crc7_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Stop offering beats and let every readout drain before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ck_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the end-bit mode register: setup cycle, then access cycle.
    task automatic write_end_bit(input logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mmc_crc7_pkg::REG_END_BIT_MODE, 2'b00};
        pwdata  <= {{(mmc_crc7_pkg::APB_DATA_W-1){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Output side: random stalls, or one long hold-off when asked for.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired with %0d result beats outstanding",
                 $time, ck_pending);
        $display("** mmc_crc7_serial_and_bus_lanes_top: FAILED **");
        $finish;
    end

    // Stimulus sequence and verdict.
    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        mode          <= mmc_crc7_pkg::MODE_DATA;
        data_byte     <= '0;
        hold_req      <= 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        beats_sent    = 0;
        finishes_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, plain CRCs: empty run, byte extremes, back-to-back finishes.
        write_end_bit(1'b0);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'hff);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'h00);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'hff);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'h00);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'h80);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'h01);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'h55);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'haa);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'h5a);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'hff);
        settle();

        // Directed, end bit appended.
        write_end_bit(1'b1);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'h00);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'hff);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'h7f);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'h00);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'hff);
        send_item(mmc_crc7_pkg::MODE_DATA, 8'ha5);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'h3c);
        send_item(mmc_crc7_pkg::MODE_FINISH, 8'h00);
        settle();

        // Random runs under each idling pattern, alternating the end-bit mode.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            write_end_bit(ph[0]);
            begin
                int start;
                start = beats_sent;
                while (beats_sent - start < ITEMS_PER_PHASE)
                begin
                    send_run();
                end
            end
            settle();
        end

        // Long output hold-off while short runs keep arriving.
        idle_pct  = 0;
        stall_pct = 0;
        write_end_bit(1'b0);
        hold_req <= 1'b1;
        repeat (12)
        begin
            send_item(mmc_crc7_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
            send_item(mmc_crc7_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
            send_item(mmc_crc7_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
        end
        settle();

        $display("Sent %0d input beats (%0d finishes); checked %0d result beats.",
                 beats_sent, finishes_sent, ck_beats);
        $display("Covered both end-bit settings, four idling patterns and a long"
                 , " output hold-off that backed up the input.");
        if (ck_fails == 0 && ck_pending == 0)
            $display("** mmc_crc7_serial_and_bus_lanes_top: PASSED **");
        else
            $display("** mmc_crc7_serial_and_bus_lanes_top: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mmc_crc7_pkg.sv
rtl/mmc_crc7_lane.sv
rtl/mmc_crc7_merge.sv
rtl/mmc_crc7_serial_and_bus_lanes_top.sv
sim/mmc_crc7_readout_checker.sv
sim/tb_mmc_crc7_serial_and_bus_lanes_top.sv
